// ===== sv/rcpi_pkg.sv =====
// Shared types and constants for the ray against convex polygon intersection block.
`timescale 1ns / 1ps
package rcpi_pkg;

  typedef struct packed {
    logic              mode;
    logic [4:0]        entry_index;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic signed [31:0] plane_offset;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [30:0] hit_distance;
  } out_word_t;

  typedef struct packed {
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    logic signed [31:0] nz;
    logic signed [31:0] ofs;
  } plane_t;

  // Request from the sequencer to the divider.
  typedef struct packed {
    logic               start;
    logic signed [50:0] num;
    logic signed [49:0] den;
  } div_req_t;

  localparam logic       MODE_LOAD  = 1'b0;
  localparam logic       MODE_QUERY = 1'b1;

  localparam logic [1:0] STATUS_LOAD = 2'd0;
  localparam logic [1:0] STATUS_MISS = 2'd1;
  localparam logic [1:0] STATUS_HIT  = 2'd2;

  localparam logic [1:0] REG_SIDE_COUNT = 2'd0;
  localparam logic [1:0] REG_PLANE_TOL  = 2'd1;
  localparam logic [1:0] REG_ZERO_TOL   = 2'd2;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_DOT,
    ST_EVAL,
    ST_DIV,
    ST_UPDATE,
    ST_FINISH
  } state_t;

endpackage

// ===== sv/rcpi_div.sv =====
// Bit-serial restoring divider producing a saturated Q16.16 quotient.
`timescale 1ns / 1ps
module rcpi_div import rcpi_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  div_req_t           req,
  output logic               done,
  output logic signed [31:0] quot
);

  logic [50:0] nb;
  logic [49:0] na;
  logic        sat;
  logic [79:0] rem_ext;
  logic [79:0] diff;
  logic        ge;

  logic        busy_r;
  logic        done_r;
  logic [4:0]  cnt_r;
  logic [66:0] rem_r;
  logic [79:0] dsh_r;
  logic [31:0] qmag_r;
  logic        neg_r;

  always_comb begin
    nb      = req.num[50] ? 51'(-req.num) : 51'(req.num);
    na      = req.den[49] ? 50'(-req.den) : 50'(req.den);
    // Integer part of the quotient reaches 2^15 or more: saturate.
    sat     = {14'd0, nb} >= ({15'd0, na} << 15);
    rem_ext = {13'd0, rem_r};
    ge      = rem_ext >= dsh_r;
    diff    = rem_ext - dsh_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        neg_r <= req.num[50] ^ req.den[49];
        if (sat) begin
          qmag_r <= 32'h8000_0000;
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
          cnt_r  <= '0;
          rem_r  <= {nb, 16'd0};
          dsh_r  <= {na, 30'd0};
          qmag_r <= '0;
        end
      end else if (busy_r) begin
        qmag_r <= {qmag_r[30:0], ge};
        if (ge) begin
          rem_r <= diff[66:0];
        end
        dsh_r <= dsh_r >> 1;
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd30) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (neg_r) begin
      quot = qmag_r[31] ? Q_MIN : -$signed(qmag_r);
    end else begin
      quot = qmag_r[31] ? Q_MAX : $signed(qmag_r);
    end
  end

  assign done = done_r;

endmodule

// ===== sv/ray_convex_polygon_intersect_top.sv =====
// Top level: plane table, register port and query sequencer for ray against convex polygon.
`timescale 1ns / 1ps
// A load word passes from acceptance through the finish state to its result word.
// A query word visits each plane in turn: a table read, the shared 32x32 multiplier
// for both dot products, an evaluate step, the bit-serial divider (skipped when the
// direction term is near zero) and an update step, over planes 0..side_count (capped
// at MAX_SIDES) or until a miss. One word is in flight at a time.
// Reset is synchronous and active low; it restores the register defaults and
// the control state, while the plane table keeps whatever it held.
module ray_convex_polygon_intersect_top import rcpi_pkg::*; #(
  parameter int MAX_SIDES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_word_t   out_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int DEPTH = MAX_SIDES + 1;
  localparam int IW    = $clog2(DEPTH);

  // Configuration registers.
  logic [4:0]  side_count_r;
  logic [15:0] plane_tol_r;
  logic [15:0] zero_tol_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_count_r <= '0;
      plane_tol_r  <= 16'd66;
      zero_tol_r   <= 16'd1;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_SIDE_COUNT: side_count_r <= cfg_pwdata[4:0];
        REG_PLANE_TOL:  plane_tol_r  <= cfg_pwdata[15:0];
        REG_ZERO_TOL:   zero_tol_r   <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_SIDE_COUNT: cfg_prdata = {27'd0, side_count_r};
      REG_PLANE_TOL:  cfg_prdata = {16'd0, plane_tol_r};
      REG_ZERO_TOL:   cfg_prdata = {16'd0, zero_tol_r};
      default:        cfg_prdata = '0;
    endcase
  end

  // Sequencer registers.
  state_t             state_r, state_nxt;
  logic [IW-1:0]      plane_idx_r, plane_idx_nxt;
  logic [2:0]         step_r, step_nxt;
  logic signed [49:0] acc_a_r, acc_a_nxt;
  logic signed [49:0] acc_v_r, acc_v_nxt;
  logic signed [63:0] prod_r, prod_nxt;
  logic signed [31:0] lo_r, lo_nxt;
  logic signed [31:0] hi_r, hi_nxt;
  logic               a_neg_r, a_neg_nxt;
  out_word_t          res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_word_t          out_data_r, out_data_nxt;
  logic signed [31:0] org_r [3];
  logic signed [31:0] dir_r [3];

  // Plane table: written by load words, read at the current plane index.
  plane_t mem [DEPTH];
  plane_t rd_r;
  logic   in_acc;
  logic   idx_ok;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid & in_ready;
  assign idx_ok    = {27'd0, in_data.entry_index} <= 32'(MAX_SIDES);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (in_acc && in_data.mode == MODE_LOAD && idx_ok) begin
      mem[IW'(in_data.entry_index)] <= '{nx: in_data.vec_x, ny: in_data.vec_y,
                                         nz: in_data.vec_z, ofs: in_data.plane_offset};
    end
    rd_r <= mem[plane_idx_r];
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      org_r[0] <= in_data.vec_x;
      org_r[1] <= in_data.vec_y;
      org_r[2] <= in_data.vec_z;
      dir_r[0] <= in_data.dir_x;
      dir_r[1] <= in_data.dir_y;
      dir_r[2] <= in_data.dir_z;
    end
  end

  // Divider shared by every plane.
  div_req_t           div_req;
  logic               div_done;
  logic signed [31:0] div_q;

  rcpi_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quot  (div_q)
  );

  // Operands of the shared multiplier: origin terms first, then direction terms.
  logic signed [31:0] mul_a, mul_b;
  logic signed [47:0] term;
  logic signed [50:0] b_val;
  logic [49:0]        a_mag;
  logic [50:0]        b_mag;
  logic               a_zero;
  logic [31:0]        n_lim;
  logic [IW-1:0]      n_sides;
  logic               last_plane;
  logic               advance, miss;

  always_comb begin
    unique case (step_r)
      3'd0:    begin mul_a = org_r[0]; mul_b = rd_r.nx; end
      3'd1:    begin mul_a = org_r[1]; mul_b = rd_r.ny; end
      3'd2:    begin mul_a = org_r[2]; mul_b = rd_r.nz; end
      3'd3:    begin mul_a = dir_r[0]; mul_b = rd_r.nx; end
      3'd4:    begin mul_a = dir_r[1]; mul_b = rd_r.ny; end
      default: begin mul_a = dir_r[2]; mul_b = rd_r.nz; end
    endcase
    // Floor of each product by 2^16.
    term   = prod_r[63:16];
    b_val  = {{19{rd_r.ofs[31]}}, rd_r.ofs} - {acc_a_r[49], acc_a_r};
    a_mag  = acc_v_r[49] ? 50'(-acc_v_r) : 50'(acc_v_r);
    b_mag  = b_val[50] ? 51'(-b_val) : 51'(b_val);
    a_zero = (acc_v_r == '0) || (a_mag < {34'd0, zero_tol_r});
    n_lim  = ({27'd0, side_count_r} > 32'(MAX_SIDES)) ? 32'(MAX_SIDES)
                                                     : {27'd0, side_count_r};
    n_sides    = n_lim[IW-1:0];
    last_plane = (plane_idx_r == n_sides);
  end

  always_comb begin
    state_nxt     = state_r;
    plane_idx_nxt = plane_idx_r;
    step_nxt      = step_r;
    acc_a_nxt     = acc_a_r;
    acc_v_nxt     = acc_v_r;
    prod_nxt      = prod_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    a_neg_nxt     = a_neg_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_data_nxt  = out_data_r;
    div_req       = '{start: 1'b0, num: b_val, den: acc_v_r};
    advance       = 1'b0;
    miss          = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data.mode == MODE_LOAD) begin
            res_nxt   = '{status: STATUS_LOAD, hit_distance: '0};
            state_nxt = ST_FINISH;
          end else begin
            plane_idx_nxt = '0;
            state_nxt     = ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        step_nxt  = '0;
        acc_a_nxt = '0;
        acc_v_nxt = '0;
        state_nxt = ST_DOT;
      end
      ST_DOT: begin
        prod_nxt = mul_a * mul_b;
        if (step_r != 3'd0) begin
          if (step_r <= 3'd3) begin
            acc_a_nxt = acc_a_r + 50'(term);
          end else begin
            acc_v_nxt = acc_v_r + 50'(term);
          end
        end
        step_nxt = step_r + 3'd1;
        if (step_r == 3'd6) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        a_neg_nxt = acc_v_r[49];
        if (!a_zero) begin
          div_req.start = 1'b1;
          state_nxt     = ST_DIV;
        end else if (plane_idx_r == '0) begin
          // Ray parallel to the supporting plane: on the plane or no hit.
          if (b_mag <= {35'd0, plane_tol_r}) begin
            lo_nxt  = '0;
            hi_nxt  = Q_MAX;
            advance = 1'b1;
          end else begin
            miss = 1'b1;
          end
        end else if (b_val[50]) begin
          miss = 1'b1;
        end else begin
          advance = 1'b1;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (plane_idx_r == '0) begin
          // Entry distance behind the origin is a miss.
          if (div_q[31]) begin
            miss = 1'b1;
          end else begin
            lo_nxt  = div_q;
            hi_nxt  = div_q;
            advance = 1'b1;
          end
        end else begin
          if (a_neg_r && div_q > lo_r) begin
            lo_nxt = div_q;
          end else if (!a_neg_r && div_q < hi_r) begin
            hi_nxt = div_q;
          end
          if (hi_nxt < lo_nxt) begin
            miss = 1'b1;
          end else begin
            advance = 1'b1;
          end
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (miss) begin
      res_nxt   = '{status: STATUS_MISS, hit_distance: '0};
      state_nxt = ST_FINISH;
    end else if (advance) begin
      if (last_plane) begin
        res_nxt   = '{status: STATUS_HIT, hit_distance: lo_nxt[30:0]};
        state_nxt = ST_FINISH;
      end else begin
        plane_idx_nxt = plane_idx_r + IW'(1);
        state_nxt     = ST_FETCH;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      plane_idx_r <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      plane_idx_r <= plane_idx_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_a_r    <= acc_a_nxt;
    acc_v_r    <= acc_v_nxt;
    prod_r     <= prod_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    a_neg_r    <= a_neg_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
